// ===== rtl/jse_pkg.sv =====
// Package with the shared types, character constants and helpers of the JSON string escaper.
package jse_pkg;

    localparam int JSE_MAX_RES  = 8;
    localparam int JSE_IDX_W    = 3;
    localparam int JSE_BODY_MAX = 6;
    localparam int JSE_QDEPTH   = 4;

    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] C_BS = 8'h08;
    localparam logic [7:0] C_FF = 8'h0C;
    localparam logic [7:0] C_LF = 8'h0A;
    localparam logic [7:0] C_CR = 8'h0D;
    localparam logic [7:0] C_HT = 8'h09;
    localparam logic [7:0] C_LOW_B = 8'h62;
    localparam logic [7:0] C_LOW_F = 8'h66;
    localparam logic [7:0] C_LOW_N = 8'h6E;
    localparam logic [7:0] C_LOW_R = 8'h72;
    localparam logic [7:0] C_LOW_T = 8'h74;
    localparam logic [7:0] C_LOW_U = 8'h75;
    localparam logic [7:0] C_ZERO  = 8'h30;

    typedef struct packed {
        logic [JSE_MAX_RES-1:0][7:0] chars;
        logic [JSE_IDX_W-1:0]        last_idx;
        logic                        str_end;
    } t_desc;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = C_ZERO + {4'd0, nib};
        end else begin
            ch = 8'h61 + {4'd0, nib - 4'd10};
        end
        return ch;
    endfunction

endpackage

// ===== rtl/jse_front.sv =====
// Front stage: accepts input beats and expands each byte into a result descriptor.
module jse_front
    import jse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_first_of_string,
    input  logic        i_last_of_string,
    input  logic        i_empty_string,
    input  logic        i_q_full,
    output logic        o_push,
    output t_desc       o_desc
);

    logic                 r_valid;
    logic                 n_valid;
    t_desc                r_desc;
    t_desc                n_desc;
    logic                 accept;
    logic [7:0]           body [JSE_BODY_MAX];
    logic [JSE_IDX_W-1:0] body_len;
    logic [JSE_IDX_W-1:0] off;
    logic [3:0]           rel;
    logic [3:0]           last_sum;
    logic [7:0]           short_ch;

    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_desc  = r_desc;

    always_comb begin
        case (i_in_byte)
            C_QUOTE:  short_ch = C_QUOTE;
            C_BSLASH: short_ch = C_BSLASH;
            C_BS:     short_ch = C_LOW_B;
            C_FF:     short_ch = C_LOW_F;
            C_LF:     short_ch = C_LOW_N;
            C_CR:     short_ch = C_LOW_R;
            C_HT:     short_ch = C_LOW_T;
            default:  short_ch = 8'h00;
        endcase
    end

    always_comb begin
        body[0] = C_BSLASH;
        body[1] = short_ch;
        body[2] = C_ZERO;
        body[3] = C_ZERO;
        body[4] = hex_digit(i_in_byte[7:4]);
        body[5] = hex_digit(i_in_byte[3:0]);
        body_len = JSE_IDX_W'(2);
        if (short_ch == 8'h00) begin
            if (i_in_byte < C_CTRL_LIMIT) begin
                body[1]  = C_LOW_U;
                body_len = JSE_IDX_W'(6);
            end else begin
                body[0]  = i_in_byte;
                body_len = JSE_IDX_W'(1);
            end
        end
    end

    always_comb begin
        off = i_first_of_string ? JSE_IDX_W'(1) : JSE_IDX_W'(0);
        rel = 4'd0;
        n_desc.chars = '0;
        for (int i = 0; i < JSE_MAX_RES; i++) begin
            rel = 4'(i) - {1'b0, off};
            n_desc.chars[i] = C_QUOTE;
            if ((4'(i) >= {1'b0, off}) && (rel < {1'b0, body_len})) begin
                n_desc.chars[i] = body[rel[2:0]];
            end
        end
        last_sum = {1'b0, off} + {1'b0, body_len} - 4'd1 + {3'd0, i_last_of_string};
        n_desc.last_idx = last_sum[JSE_IDX_W-1:0];
        n_desc.str_end  = i_last_of_string;
        if (i_empty_string) begin
            n_desc.chars[0] = C_QUOTE;
            n_desc.chars[1] = C_QUOTE;
            n_desc.last_idx = JSE_IDX_W'(1);
            n_desc.str_end  = 1'b1;
        end
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

// ===== rtl/jse_queue.sv =====
// Short descriptor queue between the front and back stages.
module jse_queue
    import jse_pkg::*;
#(
    parameter int Depth = JSE_QDEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_desc             r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic [PtrW-1:0]   n_wr_ptr;
    logic [PtrW-1:0]   n_rd_ptr;
    logic [CntW-1:0]   n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== rtl/jse_back.sv =====
// Back stage: walks each descriptor and drives one output beat per cycle while i_stall is low.
module jse_back
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_desc      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_string_end
);

    logic                 r_valid;
    logic                 n_valid;
    logic [JSE_IDX_W-1:0] r_idx;
    logic [JSE_IDX_W-1:0] n_idx;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic                 r_end;
    logic                 load;
    logic                 at_last;

    assign load    = i_head_valid && (!r_valid || !i_stall);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = at_last ? '0 : r_idx + JSE_IDX_W'(1);
        end
        if (load) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.chars[r_idx];
            r_last <= at_last;
            r_end  <= at_last && i_head.str_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_string_end  = r_end;

endmodule

// ===== rtl/json_string_escaper_unit.sv =====
// Top level of the streaming JSON string escaper.
//
// Input channel: i_valid / o_stall carry one raw string byte per beat with
// its framing flags; a beat is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carry one character of the
// quoted, escaped string per beat, with o_last_of_run on the final character
// of each input beat and o_string_end on a closing quote.
// An accepted input beat passes through the front register, the descriptor
// queue and the output register. While i_stall is low the output side
// delivers one character per cycle; an input beat expands to one to eight
// characters, and plain bytes sustain one beat per cycle.
// The descriptor queue absorbs short bursts of expansion before o_stall
// rises. When the receiver holds i_stall, the output beat stays unchanged,
// the queue fills and the input side stalls in turn.
// A synchronous reset on i_rst_n empties the front register, the queue and
// the output register; no output beat is valid after reset.
module json_string_escaper_unit
    import jse_pkg::*;
#(
    parameter int QueueDepth = JSE_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_first_of_string,
    input  logic       i_last_of_string,
    input  logic       i_empty_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_string_end
);

    logic  q_full;
    logic  push;
    t_desc front_desc;
    logic  head_valid;
    t_desc head_desc;
    logic  pop;

    jse_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_in_byte         (i_in_byte),
        .i_first_of_string (i_first_of_string),
        .i_last_of_string  (i_last_of_string),
        .i_empty_string    (i_empty_string),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_desc            (front_desc)
    );

    jse_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_desc  (head_desc)
    );

    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head_desc),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_string_end  (o_string_end)
    );

endmodule

// ===== rtl/jse_checker.sv =====
// Port-level checker for the JSON string escaper and its bind to the top level.
module jse_checker
    import jse_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run,
    input logic       o_string_end
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_string_end))
        else $error("Stalled output beat changed.");

    a_end_is_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_end |-> (o_out_byte == C_QUOTE) && o_last_of_run)
        else $error("String end flagged on a beat that is not a closing quote.");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run && !i_stall |=> o_valid)
        else $error("An unfinished run left a gap in the output.");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("Output beat valid right after reset.");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run),
    .o_string_end  (o_string_end)
);
